/* rtl/rrect_pkg.sv */
// ----------------------------------------------------------------------------
// rrect_pkg
// Shared types and constants for the rounded rectangle alpha fill unit.
// ----------------------------------------------------------------------------
package rrect_pkg;

  // Defaults for top level parameters
  localparam int COORD_WIDTH_DEF = 16;
  localparam int MID_DEPTH_DEF   = 2;
  localparam int OUT_DEPTH_DEF   = 2;

  // Field widths
  localparam int PXW        = 15;   // pixel coordinate
  localparam int CLRW       = 32;   // pixel / color word
  localparam int ALW        = 8;    // alpha
  localparam int CHW        = 8;    // one color channel
  localparam int NCH        = 3;    // blended channels (B, G, R)
  localparam int CLIP_FW    = 16;   // one clip window field
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Internal arithmetic widths
  localparam int EW  = 20;          // signed coordinate math
  localparam int RW  = 15;          // clamped radius and corner offsets
  localparam int SQW = 2 * RW;      // squared offsets
  localparam int DW  = RW + 1;      // coverage divisor 2r-1
  localparam int QW  = 9;           // coverage quotient, 0..256

  localparam logic [QW-1:0]  COV_FULL     = QW'(256);
  localparam logic [ALW-1:0] ALPHA_OPAQUE = ALW'(255);

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_LEFT     = 3'd0,
    REG_RECT_TOP      = 3'd1,
    REG_RECT_WIDTH    = 3'd2,
    REG_RECT_HEIGHT   = 3'd3,
    REG_CORNER_RADIUS = 3'd4,
    REG_FILL_COLOR    = 3'd5,
    REG_FILL_ALPHA    = 3'd6,
    REG_CLIP_WINDOW   = 3'd7
  } cfg_reg_t;

  // Settings the back end needs, derived in the front end
  typedef struct packed {
    logic [CLRW-1:0] fill_color;
    logic [ALW-1:0]  fill_alpha;
    logic [SQW-1:0]  rsq;      // r*r
    logic [SQW-1:0]  inner;    // (r-1)*(r-1)
    logic [DW-1:0]   dvs;      // 2r-1
  } fe_cfg_t;

  // Classified pixel request passed from front to back
  typedef struct packed {
    logic [CLRW-1:0] bg;
    logic            draw;
    logic            corner;
    logic [RW-1:0]   dx;
    logic [RW-1:0]   dy;
  } mid_item_t;

endpackage

/* rtl/rrect_fifo.sv */
// ----------------------------------------------------------------------------
// rrect_fifo
// Small synchronous queue; full/empty status is decoded from a registered count.
// ----------------------------------------------------------------------------
module rrect_fifo import rrect_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  // pointers and count; pointers wrap at the last entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* rtl/rrect_front.sv */
// ----------------------------------------------------------------------------
// rrect_front
// Settings registers and pixel classifier: rectangle and clip tests,
// radius clamp and distance past the inner corner square.
// ----------------------------------------------------------------------------
module rrect_front import rrect_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [PXW-1:0]        in_pixel_x,
  input  logic [PXW-1:0]        in_pixel_y,
  input  logic [CLRW-1:0]       in_background,
  output logic                  mid_push,
  output mid_item_t             mid_item,
  input  logic                  mid_full,
  output fe_cfg_t               cfg_o
);

  localparam logic signed [EW-1:0] ZERO_E = '0;
  localparam logic signed [EW-1:0] ONE_E  = EW'(1);

  // Settings registers
  logic signed [COORD_WIDTH-1:0] left_r, top_r, width_r, height_r, radius_r;
  logic [CLRW-1:0]               color_r;
  logic [ALW-1:0]                alpha_r;
  logic [CFG_DATA_W-1:0]         clip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      radius_r <= '0;
      color_r  <= '0;
      alpha_r  <= '0;
      clip_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_RECT_LEFT:     left_r   <= cfg_wdata[COORD_WIDTH-1:0];
        REG_RECT_TOP:      top_r    <= cfg_wdata[COORD_WIDTH-1:0];
        REG_RECT_WIDTH:    width_r  <= cfg_wdata[COORD_WIDTH-1:0];
        REG_RECT_HEIGHT:   height_r <= cfg_wdata[COORD_WIDTH-1:0];
        REG_CORNER_RADIUS: radius_r <= cfg_wdata[COORD_WIDTH-1:0];
        REG_FILL_COLOR:    color_r  <= cfg_wdata[CLRW-1:0];
        REG_FILL_ALPHA:    alpha_r  <= cfg_wdata[ALW-1:0];
        REG_CLIP_WINDOW:   clip_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sign-extended settings
  logic signed [EW-1:0] left_e, top_e, width_e, height_e, radius_e;
  logic signed [EW-1:0] half_w, half_h, r_pos, r_cw, rc_nxt;

  assign left_e   = EW'(left_r);
  assign top_e    = EW'(top_r);
  assign width_e  = EW'(width_r);
  assign height_e = EW'(height_r);
  assign radius_e = EW'(radius_r);

  // Halves truncate toward zero
  assign half_w = $signed(width_e + {{(EW-1){1'b0}}, width_e[EW-1]}) >>> 1;
  assign half_h = $signed(height_e + {{(EW-1){1'b0}}, height_e[EW-1]}) >>> 1;

  // Radius clamp: at least 0, at most half width, then half height
  always_comb begin
    r_pos  = (radius_e < ZERO_E) ? ZERO_E : radius_e;
    r_cw   = (r_pos > half_w) ? half_w : r_pos;
    rc_nxt = (r_cw > half_h) ? half_h : r_cw;
  end

  // Derived settings, first level
  logic signed [EW-1:0] rc_r;
  logic [CLIP_FW:0]     clip_xe_r, clip_ye_r;

  always_ff @(posedge clk) begin
    rc_r      <= rc_nxt;
    clip_xe_r <= {1'b0, clip_r[0 +: CLIP_FW]} + {1'b0, clip_r[2*CLIP_FW +: CLIP_FW]};
    clip_ye_r <= {1'b0, clip_r[CLIP_FW +: CLIP_FW]} + {1'b0, clip_r[3*CLIP_FW +: CLIP_FW]};
  end

  // Derived settings, second level
  logic [RW-1:0]        rc_u, rc_m1;
  logic signed [EW-1:0] wr1_r, hr1_r;
  logic [SQW-1:0]       rsq_r, inner_r;
  logic [DW-1:0]        dvs_r;

  assign rc_u  = rc_r[RW-1:0];
  assign rc_m1 = rc_u - RW'(1);

  always_ff @(posedge clk) begin
    wr1_r   <= width_e - ONE_E - rc_r;
    hr1_r   <= height_e - ONE_E - rc_r;
    rsq_r   <= rc_u * rc_u;
    inner_r <= rc_m1 * rc_m1;
    dvs_r   <= {rc_u, 1'b0} - DW'(1);
  end

  assign cfg_o.fill_color = color_r;
  assign cfg_o.fill_alpha = alpha_r;
  assign cfg_o.rsq        = rsq_r;
  assign cfg_o.inner      = inner_r;
  assign cfg_o.dvs        = dvs_r;

  // Pipeline control: freezes only when the last stage cannot hand off
  logic adv;
  logic s0_v_r, s1_v_r, s2_v_r;

  assign adv      = !(s2_v_r && mid_full);
  assign in_full  = !adv;
  assign mid_push = s2_v_r && !mid_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_push;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
    end
  end

  // Stage 0: input register
  logic [PXW-1:0]  px0_r, py0_r;
  logic [CLRW-1:0] bg0_r;

  always_ff @(posedge clk) begin
    if (adv && in_push) begin
      px0_r <= in_pixel_x;
      py0_r <= in_pixel_y;
      bg0_r <= in_background;
    end
  end

  // Stage 1: offsets from the rectangle origin, clip test
  logic signed [EW-1:0] u1_r, v1_r;
  logic                 ok1_r, clip_ok;
  logic [CLRW-1:0]      bg1_r;

  assign clip_ok = (CLIP_FW'(px0_r) >= clip_r[0 +: CLIP_FW])
                && ((CLIP_FW+1)'(px0_r) < clip_xe_r)
                && (CLIP_FW'(py0_r) >= clip_r[CLIP_FW +: CLIP_FW])
                && ((CLIP_FW+1)'(py0_r) < clip_ye_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      u1_r  <= $signed(EW'(px0_r)) - left_e;
      v1_r  <= $signed(EW'(py0_r)) - top_e;
      ok1_r <= clip_ok && (alpha_r != '0);
      bg1_r <= bg0_r;
    end
  end

  // Stage 2: rectangle test and corner offsets
  logic                 rect_ok, draw;
  logic                 x_lo, x_hi, y_lo, y_hi;
  logic signed [EW-1:0] dx_e, dy_e;

  always_comb begin
    rect_ok = (u1_r >= ZERO_E) && (u1_r < width_e)
           && (v1_r >= ZERO_E) && (v1_r < height_e);
    draw    = ok1_r && rect_ok;
    x_lo    = u1_r < rc_r;
    x_hi    = u1_r > wr1_r;
    y_lo    = v1_r < rc_r;
    y_hi    = v1_r > hr1_r;
    dx_e    = ZERO_E;
    if (x_lo) begin
      dx_e = rc_r - u1_r;
    end else if (x_hi) begin
      dx_e = u1_r - wr1_r;
    end
    dy_e = ZERO_E;
    if (y_lo) begin
      dy_e = rc_r - v1_r;
    end else if (y_hi) begin
      dy_e = v1_r - hr1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_item.bg     <= bg1_r;
      mid_item.draw   <= draw;
      mid_item.corner <= draw && (rc_r > ZERO_E) && (x_lo || x_hi) && (y_lo || y_hi);
      mid_item.dx     <= dx_e[RW-1:0];
      mid_item.dy     <= dy_e[RW-1:0];
    end
  end

endmodule

/* rtl/rrect_back.sv */
// ----------------------------------------------------------------------------
// rrect_back
// Shading pipeline: corner distance, coverage divider (one quotient bit
// per stage), alpha scaling and per-channel blend.
// ----------------------------------------------------------------------------
module rrect_back import rrect_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  fe_cfg_t         cfg,
  input  mid_item_t       mid_item,
  input  logic            mid_empty,
  output logic            mid_pop,
  input  logic            out_full,
  output logic            out_push,
  output logic            out_we,
  output logic [CLRW-1:0] out_value
);

  typedef struct packed {
    logic [CLRW-1:0] bg;
    logic            draw;
    logic            corner;
    logic            cut;    // outside the rounded corner
    logic            band;   // in the anti-aliased corner band
  } tag_t;

  // Whole pipeline advances together; stalls only on a full result queue
  logic adv;
  logic v1_r, v2_r, v3_r, va_r, vb_r;
  logic dv_r [QW];

  assign adv      = !(vb_r && out_full);
  assign mid_pop  = adv && !mid_empty;
  assign out_push = vb_r && !out_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
      for (int i = 0; i < QW; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else if (adv) begin
      v1_r  <= !mid_empty;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      dv_r[0] <= v3_r;
      for (int i = 1; i < QW; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
      va_r <= dv_r[QW-1];
      vb_r <= va_r;
    end
  end

  // Stage 1: squares of the corner offsets
  tag_t           tag1_r;
  logic [SQW-1:0] sqx_r, sqy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1_r.bg     <= mid_item.bg;
      tag1_r.draw   <= mid_item.draw;
      tag1_r.corner <= mid_item.corner;
      tag1_r.cut    <= 1'b0;
      tag1_r.band   <= 1'b0;
      sqx_r         <= mid_item.dx * mid_item.dx;
      sqy_r         <= mid_item.dy * mid_item.dy;
    end
  end

  // Stage 2: squared distance
  tag_t         tag2_r;
  logic [SQW:0] d2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      tag2_r <= tag1_r;
      d2_r   <= {1'b0, sqx_r} + {1'b0, sqy_r};
    end
  end

  // Stage 3: corner classification and coverage numerator
  tag_t          tag3_r, tag3_nxt;
  logic [DW-1:0] diff3_r;
  logic [SQW:0]  diff_full;
  logic          is_cut;

  assign diff_full = d2_r - {1'b0, cfg.inner};
  assign is_cut    = tag2_r.corner && (d2_r > {1'b0, cfg.rsq});

  always_comb begin
    tag3_nxt      = tag2_r;
    tag3_nxt.cut  = is_cut;
    tag3_nxt.band = tag2_r.corner && !is_cut && (d2_r > {1'b0, cfg.inner});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag3_r  <= tag3_nxt;
      diff3_r <= diff_full[DW-1:0];
    end
  end

  // Coverage divider: (diff * 256) / (2r-1), one quotient bit per stage.
  // diff never exceeds the divisor, so the first step yields the top bit.
  tag_t          dtag_r [QW];
  logic [DW-1:0] drem_r [QW];
  logic [QW-1:0] dq_r   [QW];
  logic [DW:0]   t_w    [QW];
  logic [QW-1:0] qin_w  [QW];
  tag_t          tin_w  [QW];

  for (genvar gi = 0; gi < QW; gi++) begin : g_div
    logic          bit_w;
    logic [DW:0]   sub_w;

    if (gi == 0) begin : g_first
      assign t_w[gi]   = {1'b0, diff3_r};
      assign qin_w[gi] = '0;
      assign tin_w[gi] = tag3_r;
    end else begin : g_next
      assign t_w[gi]   = {drem_r[gi-1], 1'b0};
      assign qin_w[gi] = dq_r[gi-1];
      assign tin_w[gi] = dtag_r[gi-1];
    end

    assign bit_w = t_w[gi] >= {1'b0, cfg.dvs};
    assign sub_w = t_w[gi] - {1'b0, cfg.dvs};

    always_ff @(posedge clk) begin
      if (adv) begin
        dtag_r[gi] <= tin_w[gi];
        drem_r[gi] <= bit_w ? sub_w[DW-1:0] : t_w[gi][DW-1:0];
        dq_r[gi]   <= {qin_w[gi][QW-2:0], bit_w};
      end
    end
  end

  // Alpha stage: scale alpha by coverage in the corner band
  tag_t               taga_r;
  logic [ALW-1:0]     paa_r;
  logic [QW-1:0]      cov;
  logic [ALW+QW-1:0]  prod;

  assign cov  = COV_FULL - dq_r[QW-1];
  assign prod = cfg.fill_alpha * cov;

  always_ff @(posedge clk) begin
    if (adv) begin
      taga_r <= dtag_r[QW-1];
      paa_r  <= dtag_r[QW-1].band ? prod[ALW +: ALW] : cfg.fill_alpha;
    end
  end

  // Blend stage: per channel (fill*a + bg*(255-a)) >> 8; an opaque pixel takes the fill color as is
  logic [ALW-1:0]   inv;
  logic [2*CHW-1:0] ch_sum [NCH];
  logic [CLRW-1:0]  blended;
  logic             we_nxt;
  logic [CLRW-1:0]  val_nxt;

  assign inv = ALPHA_OPAQUE - paa_r;

  always_comb begin
    blended = '0;
    for (int c = 0; c < NCH; c++) begin
      ch_sum[c] = cfg.fill_color[c*CHW +: CHW] * paa_r
                + taga_r.bg[c*CHW +: CHW] * inv;
      blended[c*CHW +: CHW] = ch_sum[c][CHW +: CHW];
    end
    we_nxt  = taga_r.draw && !taga_r.cut && (paa_r != '0);
    val_nxt = taga_r.bg;
    if (we_nxt) begin
      val_nxt = (paa_r == ALPHA_OPAQUE) ? cfg.fill_color : blended;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_we    <= we_nxt;
      out_value <= val_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // coverage numerator never exceeds the divisor in the band
  a_band_num: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && tag3_r.band |-> diff3_r <= cfg.dvs)
    else $error("coverage numerator above divisor");

  // divider output stays within full coverage
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[QW-1] && dtag_r[QW-1].band |-> dq_r[QW-1] <= COV_FULL)
    else $error("coverage quotient out of range");

  // scaled alpha never exceeds the global opacity
  a_alpha_scale: assert property (@(posedge clk) disable iff (!rst_n)
    va_r && taga_r.band |-> paa_r <= cfg.fill_alpha)
    else $error("scaled alpha above fill alpha");

  // a stalled result holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && out_full |=> vb_r && $stable(out_value) && $stable(out_we))
    else $error("result changed while stalled");
`endif

endmodule

/* rtl/rounded_rect_alpha_fill_unit.sv */
// ----------------------------------------------------------------------------
// rounded_rect_alpha_fill_unit
// Per-pixel shader for a translucent rounded rectangle fill.
// ----------------------------------------------------------------------------
// Usage:
//   Settings are written through cfg_we/cfg_addr/cfg_wdata while no pixel is
//   in flight; a pixel may be pushed in the cycle after the last write.
//   Pixel requests enter on in_push when in_full is low: position and the
//   current background value. Each request gives exactly one result, in
//   order, on the out_ side while out_empty is low; out_pop takes it.
//   Throughput: one pixel per clock while no stall holds the pipelines,
//   set by the classifier and shading pipelines, which each take a new
//   request every cycle unless stalled.
//   A stalled receiver fills the result queue, then freezes the shading
//   pipeline; the classified-request queue fills after that and in_full
//   rises. Both sides resume without loss when out_pop returns.
//   Reset (rst_n low at a clock edge) clears all settings to zero and
//   empties both queues and pipelines.
// ----------------------------------------------------------------------------
module rounded_rect_alpha_fill_unit import rrect_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int MID_DEPTH   = MID_DEPTH_DEF,
  parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [PXW-1:0]        in_pixel_x,
  input  logic [PXW-1:0]        in_pixel_y,
  input  logic [CLRW-1:0]       in_background,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic                  out_write_enable,
  output logic [CLRW-1:0]       out_pixel_value
);

  localparam int MIDW = $bits(mid_item_t);
  localparam int OUTW = CLRW + 1;

  fe_cfg_t         fe_cfg;
  mid_item_t       fe_item, be_item;
  logic            fe_push, mid_full, mid_empty, be_pop;
  logic            be_push, be_we, res_full;
  logic [CLRW-1:0] be_value;
  logic [MIDW-1:0] mid_rdata;
  logic [OUTW-1:0] res_rdata;

  // classifier and settings
  rrect_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .in_background (in_background),
    .mid_push      (fe_push),
    .mid_item      (fe_item),
    .mid_full      (mid_full),
    .cfg_o         (fe_cfg)
  );

  // queue between classifier and shader
  rrect_fifo #(
    .WIDTH (MIDW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .wdata (fe_item),
    .full  (mid_full),
    .pop   (be_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign be_item = mid_item_t'(mid_rdata);

  // shading pipeline
  rrect_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (fe_cfg),
    .mid_item  (be_item),
    .mid_empty (mid_empty),
    .mid_pop   (be_pop),
    .out_full  (res_full),
    .out_push  (be_push),
    .out_we    (be_we),
    .out_value (be_value)
  );

  // result queue
  rrect_fifo #(
    .WIDTH (OUTW),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (be_push),
    .wdata ({be_we, be_value}),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_write_enable = res_rdata[CLRW];
  assign out_pixel_value  = res_rdata[CLRW-1:0];

endmodule

/* tb/rrect_shade_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrect_shade_checker
// Watches the settings port and both pixel queues of the rounded rectangle
// fill unit, predicts the shaded pixel for every accepted request and
// compares each popped result against the oldest prediction, in order.
// ----------------------------------------------------------------------------
module rrect_shade_checker import rrect_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic [PXW-1:0]        in_pixel_x,
  input  logic [PXW-1:0]        in_pixel_y,
  input  logic [CLRW-1:0]       in_background,
  input  logic                  out_pop,
  input  logic                  out_empty,
  input  logic                  out_write_enable,
  input  logic [CLRW-1:0]       out_pixel_value,
  output int                    fail_count,
  output int                    pending,
  output int                    results_seen,
  output int                    writes_seen
);

  localparam logic [CLRW-1:0] RB_MASK = 32'h00FF00FF;
  localparam logic [CLRW-1:0] G_MASK  = 32'h0000FF00;

  typedef struct packed {
    logic [PXW-1:0]  px;
    logic [PXW-1:0]  py;
    logic            we;
    logic [CLRW-1:0] value;
  } shaded_pixel_t;

  shaded_pixel_t expected_pixels[$];

  // Local copy of the settings, coordinates already sign-extended
  longint          rect_left, rect_top, rect_width, rect_height, corner_radius;
  logic [CLRW-1:0] fill_color;
  logic [ALW-1:0]  fill_alpha;
  logic [63:0]     clip_window;

  // Shade one pixel against the current settings
  function automatic shaded_pixel_t shade_pixel(input logic [PXW-1:0] px_in,
                                                input logic [PXW-1:0] py_in,
                                                input logic [CLRW-1:0] bg);
    longint        px, py, cx0, cy0, cw, ch, r, dx, dy, d2, inner, cov, alpha;
    longint        inv, rb, g;
    shaded_pixel_t res;
    px        = longint'(px_in);
    py        = longint'(py_in);
    cx0       = longint'(clip_window[15:0]);
    cy0       = longint'(clip_window[31:16]);
    cw        = longint'(clip_window[47:32]);
    ch        = longint'(clip_window[63:48]);
    res.px    = px_in;
    res.py    = py_in;
    res.we    = 1'b0;
    res.value = bg;
    alpha     = longint'(fill_alpha);

    // Rectangle, clip window and global opacity gate
    if (alpha == 0) return res;
    if (px < rect_left || px >= rect_left + rect_width ||
        py < rect_top || py >= rect_top + rect_height) return res;
    if (px < cx0 || px >= cx0 + cw || py < cy0 || py >= cy0 + ch) return res;

    // Radius clamp, division truncates toward zero
    r = corner_radius;
    if (r < 0) r = 0;
    if (r > rect_width / 2) r = rect_width / 2;
    if (r > rect_height / 2) r = rect_height / 2;

    // Corner cut and antialiased band
    if (r > 0) begin
      dx = 0;
      dy = 0;
      if (px < rect_left + r) dx = rect_left + r - px;
      else if (px >= rect_left + rect_width - r) dx = px - (rect_left + rect_width - 1 - r);
      if (py < rect_top + r) dy = rect_top + r - py;
      else if (py >= rect_top + rect_height - r) dy = py - (rect_top + rect_height - 1 - r);
      if (dx > 0 && dy > 0) begin
        d2    = dx * dx + dy * dy;
        inner = (r - 1) * (r - 1);
        if (d2 > r * r) return res;
        if (d2 > inner) begin
          cov = longint'(COV_FULL) - ((d2 - inner) * 256) / (2 * r - 1);
          if (cov < 0) cov = 0;
          if (cov > longint'(COV_FULL)) cov = longint'(COV_FULL);
          alpha = ((longint'(fill_alpha) * cov) >> 8) & 255;
        end
      end
    end

    // Opaque copy or 8-bit weighted blend
    if (alpha == longint'(ALPHA_OPAQUE)) begin
      res.value = fill_color;
    end else if (alpha > 0) begin
      inv = longint'(ALPHA_OPAQUE) - alpha;
      rb  = (longint'(fill_color & RB_MASK) * alpha + longint'(bg & RB_MASK) * inv) >> 8;
      g   = (longint'(fill_color & G_MASK) * alpha + longint'(bg & G_MASK) * inv) >> 8;
      res.value = CLRW'(rb) & RB_MASK | CLRW'(g) & G_MASK;
    end else begin
      return res;
    end
    res.we = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Track settings, queue predictions, compare results
  always @(posedge clk) begin
    shaded_pixel_t exp_pix;
    if (!rst_n) begin
      rect_left     = 0;
      rect_top      = 0;
      rect_width    = 0;
      rect_height   = 0;
      corner_radius = 0;
      fill_color    = '0;
      fill_alpha    = '0;
      clip_window   = '0;
      fail_count    = 0;
      results_seen  = 0;
      writes_seen   = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_RECT_LEFT:     rect_left     = longint'($signed(cfg_wdata[15:0]));
          REG_RECT_TOP:      rect_top      = longint'($signed(cfg_wdata[15:0]));
          REG_RECT_WIDTH:    rect_width    = longint'($signed(cfg_wdata[15:0]));
          REG_RECT_HEIGHT:   rect_height   = longint'($signed(cfg_wdata[15:0]));
          REG_CORNER_RADIUS: corner_radius = longint'($signed(cfg_wdata[15:0]));
          REG_FILL_COLOR:    fill_color    = cfg_wdata[CLRW-1:0];
          REG_FILL_ALPHA:    fill_alpha    = cfg_wdata[ALW-1:0];
          REG_CLIP_WINDOW:   clip_window   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_push && !in_full)
        expected_pixels.push_back(shade_pixel(in_pixel_x, in_pixel_y, in_background));
      if (out_pop && !out_empty) begin
        results_seen++;
        if (out_write_enable) writes_seen++;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting: we=%0b value=%08h",
                                    out_write_enable, out_pixel_value));
        end else begin
          exp_pix = expected_pixels.pop_front();
          if (out_write_enable !== exp_pix.we)
            report_mismatch($sformatf("pixel (%0d,%0d) write_enable exp %0b got %0b",
                                      exp_pix.px, exp_pix.py, exp_pix.we, out_write_enable));
          if (out_pixel_value !== exp_pix.value)
            report_mismatch($sformatf("pixel (%0d,%0d) pixel_value exp %08h got %08h",
                                      exp_pix.px, exp_pix.py, exp_pix.value,
                                      out_pixel_value));
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

/* tb/tb_rounded_rect_alpha_fill_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rounded_rect_alpha_fill_unit
// Drives pixel requests and settings into the rounded rectangle fill unit:
// a short directed set of edge, corner, clip and opacity cases, then random
// rectangles with pixels aimed at edges and corners, under three idle mixes.
// ----------------------------------------------------------------------------
module tb_rounded_rect_alpha_fill_unit;
  import rrect_pkg::*;

  localparam int PHASE_ITEMS = 650;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_push;
  logic                  in_full;
  logic [PXW-1:0]        in_pixel_x;
  logic [PXW-1:0]        in_pixel_y;
  logic [CLRW-1:0]       in_background;
  logic                  out_pop;
  logic                  out_empty;
  logic                  out_write_enable;
  logic [CLRW-1:0]       out_pixel_value;

  int fail_count, pending, results_seen, writes_seen;
  int send_idle_pct, recv_idle_pct;
  int settings_count;
  // Current rectangle, used only to aim the stimulus
  int cur_left, cur_top, cur_w, cur_h, cur_rc;

  rounded_rect_alpha_fill_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .in_background    (in_background),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_write_enable (out_write_enable),
    .out_pixel_value  (out_pixel_value)
  );

  rrect_shade_checker shade_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .in_background    (in_background),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_write_enable (out_write_enable),
    .out_pixel_value  (out_pixel_value),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_seen     (results_seen),
    .writes_seen      (writes_seen)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random pop at each falling edge
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      out_pop = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic logic [PXW-1:0] to_pixel(input int v);
    if (v < 0) return '0;
    if (v > 32767) return PXW'(32767);
    return PXW'(v);
  endfunction

  // One request; entered and left at a falling edge
  task automatic send_pixel(input logic [PXW-1:0] px, input logic [PXW-1:0] py,
                            input logic [CLRW-1:0] bg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push       = 1'b1;
    in_pixel_x    = px;
    in_pixel_y    = py;
    in_background = bg;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  // Hold off requests until every queued result has been popped
  task automatic drain;
    in_push = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_addr  = idx;
    cfg_wdata = data;
    @(negedge clk);
  endtask

  // Write all settings; unused upper data bits carry random noise
  task automatic apply_settings(input int left, input int top, input int w, input int h,
                                input int r, input logic [CLRW-1:0] color,
                                input logic [ALW-1:0] alpha, input logic [63:0] clip);
    logic [CFG_DATA_W-1:0] noise;
    drain();
    noise  = {$urandom, $urandom};
    cfg_we = 1'b1;
    put_reg(REG_RECT_LEFT,     {noise[63:16], 16'(left)});
    put_reg(REG_RECT_TOP,      {noise[47:0], 16'(top)});
    put_reg(REG_RECT_WIDTH,    {noise[55:8], 16'(w)});
    put_reg(REG_RECT_HEIGHT,   {noise[39:0], noise[63:56], 16'(h)});
    put_reg(REG_CORNER_RADIUS, {noise[31:0], noise[63:48], 16'(r)});
    put_reg(REG_FILL_COLOR,    {noise[63:32], color});
    put_reg(REG_FILL_ALPHA,    {noise[63:8], alpha});
    put_reg(REG_CLIP_WINDOW,   clip);
    cfg_we = 1'b0;
    settings_count++;
    cur_left = int'($signed(16'(left)));
    cur_top  = int'($signed(16'(top)));
    cur_w    = int'($signed(16'(w)));
    cur_h    = int'($signed(16'(h)));
    cur_rc   = int'($signed(16'(r)));
    if (cur_rc < 0) cur_rc = 0;
    if (cur_rc > cur_w / 2) cur_rc = cur_w / 2;
    if (cur_rc > cur_h / 2) cur_rc = cur_h / 2;
    if (cur_rc < 0) cur_rc = 0;
  endtask

  // Random settings: mostly a visible rectangle, sometimes raw noise
  task automatic pick_settings;
    int              left, top, w, h, r, cx, cy;
    logic [ALW-1:0]  alpha;
    logic [63:0]     clip;
    if ($urandom_range(0, 9) == 0) begin
      left = $urandom;
      top  = $urandom;
      w    = $urandom;
      h    = $urandom;
      r    = $urandom;
    end else begin
      left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(32600, 32767))
                                         : int'($urandom_range(0, 320)) - 20;
      top  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(32600, 32767))
                                         : int'($urandom_range(0, 320)) - 20;
      w    = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 6)) - 3
                                         : int'($urandom_range(1, 120));
      h    = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 6)) - 3
                                         : int'($urandom_range(1, 120));
      case ($urandom_range(0, 4))
        0:       r = -int'($urandom_range(1, 5));
        1:       r = 32767;
        2:       r = w / 2 + int'($urandom_range(0, 1));
        default: r = $urandom_range(0, 70);
      endcase
    end
    case ($urandom_range(0, 5))
      0, 1: alpha = ALPHA_OPAQUE;
      2: begin
        case ($urandom_range(0, 2))
          0:       alpha = '0;
          1:       alpha = ALW'(1);
          default: alpha = ALW'(254);
        endcase
      end
      default: alpha = ALW'($urandom_range(1, 254));
    endcase
    case ($urandom_range(0, 9))
      0: clip = {$urandom, $urandom};
      1, 2, 3: begin
        cx = left + int'($urandom_range(0, 40)) - 20;
        cy = top + int'($urandom_range(0, 40)) - 20;
        if (cx < 0) cx = 0;
        if (cy < 0) cy = 0;
        clip = {16'($urandom_range(0, 160)), 16'($urandom_range(0, 160)), 16'(cy), 16'(cx)};
      end
      default: clip = {16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
    endcase
    apply_settings(left, top, w, h, r, $urandom, alpha, clip);
  endtask

  // Random pixel: corner zones, around the rectangle, or anywhere
  task automatic send_random_pixel;
    int x, y, off;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        x = $urandom_range(0, 32767);
        y = $urandom_range(0, 32767);
      end
      3, 4, 5, 6, 7, 8, 9: begin
        off = $urandom_range(0, cur_rc + 1);
        x   = $urandom_range(0, 1) ? cur_left + off : cur_left + cur_w - 1 - off;
        off = $urandom_range(0, cur_rc + 1);
        y   = $urandom_range(0, 1) ? cur_top + off : cur_top + cur_h - 1 - off;
      end
      default: begin
        x = cur_left - 4 + int'($urandom_range(0, (cur_w > 0 ? cur_w : 0) + 8));
        y = cur_top - 4 + int'($urandom_range(0, (cur_h > 0 ? cur_h : 0) + 8));
      end
    endcase
    send_pixel(to_pixel(x), to_pixel(y), $urandom);
  endtask

  // Stimulus and verdict
  initial begin
    int sent, burst;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = REG_RECT_LEFT;
    cfg_wdata      = '0;
    in_push        = 1'b0;
    in_pixel_x     = '0;
    in_pixel_y     = '0;
    in_background  = '0;
    send_idle_pct  = 37;
    recv_idle_pct  = 51;
    settings_count = 0;
    cur_left = 0; cur_top = 0; cur_w = 0; cur_h = 0; cur_rc = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: zero alpha, nothing is written
    send_pixel('0, '0, 32'hFFFFFFFF);
    send_pixel(PXW'(32767), PXW'(32767), 32'h00000000);

    // Opaque rounded rectangle: corner cut, band, interior, pixels on every side
    apply_settings(10, 20, 40, 30, 8, 32'h12345678, ALPHA_OPAQUE,
                   {16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000});
    send_pixel(PXW'(10), PXW'(20), 32'hCAFEF00D);
    send_pixel(PXW'(11), PXW'(25), 32'h00000000);
    send_pixel(PXW'(30), PXW'(35), 32'hFFFFFFFF);
    send_pixel(PXW'(9),  PXW'(25), 32'h11111111);
    send_pixel(PXW'(50), PXW'(25), 32'h22222222);
    send_pixel(PXW'(49), PXW'(25), 32'h33333333);
    send_pixel(PXW'(30), PXW'(19), 32'h44444444);
    send_pixel(PXW'(30), PXW'(50), 32'h55555555);
    send_pixel(PXW'(30), PXW'(49), 32'h66666666);
    send_pixel(PXW'(49), PXW'(49), 32'h77777777);

    // Half alpha blend inside a tight clip window, clip edges on each side
    apply_settings(10, 20, 40, 30, 8, 32'hAABBCCDD, ALW'(128),
                   {16'd10, 16'd15, 16'd22, 16'd20});
    send_pixel(PXW'(30), PXW'(30), 32'hFFFFFFFF);
    send_pixel(PXW'(34), PXW'(31), 32'h00000000);
    send_pixel(PXW'(19), PXW'(30), 32'h01020304);
    send_pixel(PXW'(35), PXW'(30), 32'h05060708);
    send_pixel(PXW'(30), PXW'(32), 32'h090A0B0C);
    send_pixel(PXW'(30), PXW'(21), 32'h0D0E0F10);
    send_pixel(PXW'(11), PXW'(25), 32'h80808080);

    // Most negative corner, full size, largest radius
    apply_settings(-32768, -32768, 32767, 32767, 32767, 32'hFFFFFFFF, ALW'(1),
                   {16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000});
    send_pixel('0, '0, 32'h12345678);
    send_pixel(PXW'(32767), PXW'(32767), 32'h87654321);

    // Whole positive range, negative radius means square corners
    apply_settings(0, 0, 32767, 32767, -32768, 32'h00FF00FF, ALW'(254),
                   {16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000});
    send_pixel('0, '0, 32'hFFFFFFFF);
    send_pixel(PXW'(32766), PXW'(32766), 32'h00000000);
    send_pixel(PXW'(32767), PXW'(32767), 32'hA5A5A5A5);
    send_pixel('0, PXW'(32766), 32'h5A5A5A5A);

    // Most negative width draws nothing
    apply_settings(32767, 0, -32768, 32767, 32767, 32'hFFFFFFFF, ALPHA_OPAQUE,
                   64'hFFFFFFFFFFFFFFFF);
    send_pixel(PXW'(32767), '0, 32'hDEADBEEF);

    // Random phases with three idle mixes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 37; recv_idle_pct = 51; end
        1: begin send_idle_pct = 51; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // settings change waits for every result, which also exercises a full drain
        pick_settings();
        burst = $urandom_range(30, 110);
        for (int i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
          send_random_pixel();
          sent++;
        end
      end
    end

    // Wait out every result, then watch a while for strays
    drain();
    repeat (40) @(negedge clk);

    $display("Shaded %0d pixels across %0d settings: %0d written, %0d left unchanged.",
             results_seen, settings_count, writes_seen, results_seen - writes_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
